// ----- rtl/pbst_pkg.sv -----
package pbst_pkg;

   // Fixed field widths
   localparam int PULSE_W = 16;
   localparam int GAP_W   = 8;
   localparam int CSR_W   = 16;
   localparam int REQ_W   = 3;
   localparam int LINE_W  = 2;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 3'd0,
      REQ_START  = 3'd1,
      REQ_STOP   = 3'd2,
      REQ_PAUSE  = 3'd3,
      REQ_RESUME = 3'd4
   } req_code_type;

   // Line phase
   typedef enum logic [LINE_W-1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_GAP  = 2'd1,
      PHASE_TX   = 2'd2
   } phase_type;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_PULSE_LENGTH = 1'b0,
      CSR_GAP_PERIODS  = 1'b1
   } csr_index_type;

   // Status of the result buffer
   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

// ----- rtl/pulse_bit_serial_transmitter_unit.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_type, req_tx_word, req_side_mask
// rsp       out        rsp_valid/rsp_stall  rsp_pulse_width, rsp_drive_sides,
//                                           rsp_line_state, rsp_is_paused,
//                                           rsp_sample_window
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// One word per cycle while req_stall is low; the result is formed combinationally
// from the request and state and registered in the output register or skid stage.
// Reset is synchronous and active high; it clears state and the valid flags of both registers.
// A stalled result sits in the output register while one more word lands in
// the skid stage; req_stall rises only while the skid stage is occupied.
module pulse_bit_serial_transmitter_unit #(
   parameter int WORD_BITS  = 16,
   parameter int SIDE_COUNT = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [0:0]                    csr_index,
   input  logic [pbst_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pbst_pkg::REQ_W-1:0]    req_type,
   input  logic [WORD_BITS-1:0]          req_tx_word,
   input  logic [SIDE_COUNT-1:0]         req_side_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pbst_pkg::PULSE_W-1:0]  rsp_pulse_width,
   output logic [SIDE_COUNT-1:0]         rsp_drive_sides,
   output logic [pbst_pkg::LINE_W-1:0]   rsp_line_state,
   output logic                          rsp_is_paused,
   output logic                          rsp_sample_window
);

   localparam int DATA_W = pbst_pkg::PULSE_W + SIDE_COUNT + pbst_pkg::LINE_W + 2;

   logic                         accept;
   logic [pbst_pkg::PULSE_W-1:0] res_pulse_width;
   logic [SIDE_COUNT-1:0]        res_drive_sides;
   logic [pbst_pkg::LINE_W-1:0]  res_line_state;
   logic                         res_is_paused;
   logic                         res_sample_window;
   logic [DATA_W-1:0]            res_data;
   logic [DATA_W-1:0]            out_data;
   pbst_pkg::buf_status_type     buf_status;

   assign accept    = req_valid && !req_stall;
   assign req_stall = buf_status.skid_valid;

   // State update
   pbst_core #(
      .WORD_BITS  (WORD_BITS),
      .SIDE_COUNT (SIDE_COUNT)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .step              (accept),
      .req_type          (req_type),
      .tx_word           (req_tx_word),
      .side_mask         (req_side_mask),
      .res_pulse_width   (res_pulse_width),
      .res_drive_sides   (res_drive_sides),
      .res_line_state    (res_line_state),
      .res_is_paused     (res_is_paused),
      .res_sample_window (res_sample_window)
   );

   assign res_data = {res_pulse_width, res_drive_sides, res_line_state,
                      res_is_paused, res_sample_window};

   // Result register with skid stage
   pbst_out_buf #(
      .DATA_W (DATA_W)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (res_data),
      .pop_stall (rsp_stall),
      .out_data  (out_data),
      .status    (buf_status)
   );

   assign rsp_valid = buf_status.out_valid;
   assign {rsp_pulse_width, rsp_drive_sides, rsp_line_state,
           rsp_is_paused, rsp_sample_window} = out_data;

   // Skid stage only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> buf_status.out_valid)
      else $error("skid stage holds a word while output register is empty");

   // A word taken while the result stalls must land in the skid stage
   a_stalled_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid && rsp_stall) |=> buf_status.skid_valid)
      else $error("word accepted under stall was not kept");

   // The sample window only opens as the line enters the gap
   a_window_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_window) |-> (rsp_line_state == pbst_pkg::PHASE_GAP))
      else $error("sample window outside gap");

   // A paused line is idle
   a_paused_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_paused) |-> (rsp_line_state == pbst_pkg::PHASE_IDLE))
      else $error("paused line not idle");

endmodule

// ----- rtl/pbst_core.sv -----
module pbst_core #(
   parameter int WORD_BITS  = 16,
   parameter int SIDE_COUNT = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [0:0]                    csr_index,
   input  logic [pbst_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          step,
   input  logic [pbst_pkg::REQ_W-1:0]    req_type,
   input  logic [WORD_BITS-1:0]          tx_word,
   input  logic [SIDE_COUNT-1:0]         side_mask,
   output logic [pbst_pkg::PULSE_W-1:0]  res_pulse_width,
   output logic [SIDE_COUNT-1:0]         res_drive_sides,
   output logic [pbst_pkg::LINE_W-1:0]   res_line_state,
   output logic                          res_is_paused,
   output logic                          res_sample_window
);

   logic [pbst_pkg::PULSE_W-1:0] pulse_length_ff;
   logic [pbst_pkg::GAP_W-1:0]   gap_periods_ff;

   logic [WORD_BITS-1:0]         shift_word_ff, shift_word_in;
   logic [WORD_BITS-1:0]         buffered_word_ff, buffered_word_in;
   pbst_pkg::phase_type          phase_ff, phase_in;
   logic                         pause_flag_ff, pause_flag_in;
   logic [pbst_pkg::GAP_W-1:0]   gap_count_ff, gap_count_in;
   logic [pbst_pkg::PULSE_W-1:0] current_width_ff, current_width_in;
   logic [SIDE_COUNT-1:0]        enabled_sides_ff, enabled_sides_in;
   logic                         window;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_length_ff <= '0;
         gap_periods_ff  <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == pbst_pkg::CSR_PULSE_LENGTH) begin
            pulse_length_ff <= csr_wdata[pbst_pkg::PULSE_W-1:0];
         end else begin
            gap_periods_ff <= csr_wdata[pbst_pkg::GAP_W-1:0];
         end
      end
   end

   // Next state for one request word
   always_comb begin
      shift_word_in    = shift_word_ff;
      buffered_word_in = buffered_word_ff;
      phase_in         = phase_ff;
      pause_flag_in    = pause_flag_ff;
      gap_count_in     = gap_count_ff;
      current_width_in = current_width_ff;
      enabled_sides_in = enabled_sides_ff;
      window           = 1'b0;
      case (req_type)
         pbst_pkg::REQ_TICK: begin
            if (phase_ff == pbst_pkg::PHASE_TX) begin
               if (shift_word_ff == '0) begin
                  // empty register: enter the gap and open the sample window
                  current_width_in = '0;
                  gap_count_in     = gap_periods_ff;
                  phase_in         = pbst_pkg::PHASE_GAP;
                  window           = 1'b1;
               end else begin
                  current_width_in = shift_word_ff[WORD_BITS-1] ? pulse_length_ff : '0;
                  shift_word_in    = {shift_word_ff[WORD_BITS-2:0], 1'b0};
               end
            end else if (phase_ff == pbst_pkg::PHASE_GAP) begin
               if (gap_count_ff == '0) begin
                  shift_word_in = buffered_word_ff;
                  phase_in      = pbst_pkg::PHASE_TX;
               end else begin
                  gap_count_in = gap_count_ff - 1'b1;
               end
            end
         end
         pbst_pkg::REQ_START: begin
            buffered_word_in = tx_word;
            enabled_sides_in = side_mask;
            if (!pause_flag_ff && phase_ff == pbst_pkg::PHASE_IDLE) begin
               shift_word_in = tx_word;
               phase_in      = pbst_pkg::PHASE_TX;
            end
         end
         pbst_pkg::REQ_STOP: begin
            current_width_in = '0;
            enabled_sides_in = '0;
            phase_in         = pbst_pkg::PHASE_IDLE;
         end
         pbst_pkg::REQ_PAUSE: begin
            pause_flag_in    = 1'b1;
            current_width_in = '0;
            enabled_sides_in = '0;
            phase_in         = pbst_pkg::PHASE_IDLE;
         end
         pbst_pkg::REQ_RESUME: begin
            // enable all sides and, from idle, restart with the buffered word
            pause_flag_in    = 1'b0;
            enabled_sides_in = '1;
            if (phase_ff == pbst_pkg::PHASE_IDLE) begin
               shift_word_in = buffered_word_ff;
               phase_in      = pbst_pkg::PHASE_TX;
            end
         end
         default: begin
         end
      endcase
   end

   // Result reports the state after the request
   always_comb begin
      res_pulse_width   = current_width_in;
      res_drive_sides   = enabled_sides_in;
      res_line_state    = phase_in;
      res_is_paused     = pause_flag_in;
      res_sample_window = window;
   end

   // Advance state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff    <= '0;
         buffered_word_ff <= '0;
         phase_ff         <= pbst_pkg::PHASE_IDLE;
         pause_flag_ff    <= 1'b0;
         gap_count_ff     <= '0;
         current_width_ff <= '0;
         enabled_sides_ff <= '0;
      end else if (step) begin
         shift_word_ff    <= shift_word_in;
         buffered_word_ff <= buffered_word_in;
         phase_ff         <= phase_in;
         pause_flag_ff    <= pause_flag_in;
         gap_count_ff     <= gap_count_in;
         current_width_ff <= current_width_in;
         enabled_sides_ff <= enabled_sides_in;
      end
   end

endmodule

// ----- rtl/pbst_out_buf.sv -----
module pbst_out_buf #(
   parameter int DATA_W = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [DATA_W-1:0]        push_data,
   input  logic                     pop_stall,
   output logic [DATA_W-1:0]        out_data,
   output pbst_pkg::buf_status_type status
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic [DATA_W-1:0] skid_data_ff, skid_data_in;
   logic              take;

   assign take = out_valid_ff && !pop_stall;

   // Route a new word to the output register or the skid stage; on a take, refill or empty the output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_data          = out_data_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

   localparam int WORD_W      = 16;
   localparam int SIDE_W      = 2;
   localparam int STATUS_W    = pbst_pkg::PULSE_W;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_MAX    = 14;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [pbst_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [pbst_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
   localparam logic [SIDE_W-1:0]          ALL_SIDES     = '1;

   typedef struct packed {
      logic [pbst_pkg::PULSE_W-1:0] width;
      logic [SIDE_W-1:0]            sides;
      logic [pbst_pkg::LINE_W-1:0]  line;
      logic                         paused;
      logic                         window;
   } line_status_type;

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           csr_wr_en     = 1'b0;
   pbst_pkg::csr_index_type        csr_index     = pbst_pkg::CSR_PULSE_LENGTH;
   logic [pbst_pkg::CSR_W-1:0]     csr_wdata     = '0;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic [pbst_pkg::REQ_W-1:0]     req_type      = pbst_pkg::REQ_TICK;
   logic [WORD_W-1:0]              req_tx_word   = '0;
   logic [SIDE_W-1:0]              req_side_mask = '0;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic [pbst_pkg::PULSE_W-1:0]   rsp_pulse_width;
   logic [SIDE_W-1:0]              rsp_drive_sides;
   logic [pbst_pkg::LINE_W-1:0]    rsp_line_state;
   logic                           rsp_is_paused;
   logic                           rsp_sample_window;

   // Transmitter state as predicted
   logic [pbst_pkg::PULSE_W-1:0] pulse_cfg;
   logic [pbst_pkg::GAP_W-1:0]   gap_cfg;
   logic [WORD_W-1:0]            shift_reg;
   logic [WORD_W-1:0]            held_word;
   pbst_pkg::phase_type          tx_phase;
   logic                         paused;
   logic [pbst_pkg::GAP_W-1:0]   gap_left;
   logic [pbst_pkg::PULSE_W-1:0] line_width;
   logic [SIDE_W-1:0]            live_sides;

   line_status_type expected_status_q[$];
   int              mismatch_count = 0;
   bit              send_idle_en   = 1'b0;
   bit              recv_idle_en   = 1'b0;
   int              hold_request   = 0;

   pulse_bit_serial_transmitter_unit #(
      .WORD_BITS  (WORD_W),
      .SIDE_COUNT (SIDE_W)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_tx_word       (req_tx_word),
      .req_side_mask     (req_side_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pulse_width   (rsp_pulse_width),
      .rsp_drive_sides   (rsp_drive_sides),
      .rsp_line_state    (rsp_line_state),
      .rsp_is_paused     (rsp_is_paused),
      .rsp_sample_window (rsp_sample_window)
   );

   always #HALF_PERIOD clock = ~clock;

   // Take a word and side mask; begin sending only from idle and unpaused
   function automatic void load_word(logic [WORD_W-1:0] word, logic [SIDE_W-1:0] sides);
      held_word  = word;
      live_sides = sides;
      if (!paused && tx_phase == pbst_pkg::PHASE_IDLE) begin
         shift_reg = held_word;
         tx_phase  = pbst_pkg::PHASE_TX;
      end
   endfunction

   // Silence the line and float all sides
   function automatic void halt_line();
      line_width = '0;
      live_sides = '0;
      tx_phase   = pbst_pkg::PHASE_IDLE;
   endfunction

   // Advance the predicted transmitter by one word and queue its status
   function automatic void predict_status(logic [pbst_pkg::REQ_W-1:0] code,
                                          logic [WORD_W-1:0] word,
                                          logic [SIDE_W-1:0] sides);
      line_status_type st;
      logic            window;
      window = 1'b0;
      case (code)
         pbst_pkg::REQ_TICK: begin
            if (tx_phase == pbst_pkg::PHASE_TX) begin
               if (shift_reg == '0) begin
                  line_width = '0;
                  gap_left   = gap_cfg;
                  tx_phase   = pbst_pkg::PHASE_GAP;
                  window     = 1'b1;
               end else begin
                  line_width = shift_reg[WORD_W-1] ? pulse_cfg : '0;
                  shift_reg  = shift_reg << 1;
               end
            end else if (tx_phase == pbst_pkg::PHASE_GAP) begin
               if (gap_left == '0) begin
                  shift_reg = held_word;
                  tx_phase  = pbst_pkg::PHASE_TX;
               end else begin
                  gap_left = gap_left - 1'b1;
               end
            end
         end
         pbst_pkg::REQ_START: load_word(word, sides);
         pbst_pkg::REQ_STOP: halt_line();
         pbst_pkg::REQ_PAUSE: begin
            paused = 1'b1;
            halt_line();
         end
         pbst_pkg::REQ_RESUME: begin
            paused = 1'b0;
            load_word(held_word, ALL_SIDES);
         end
         default: ;
      endcase
      st.width  = line_width;
      st.sides  = live_sides;
      st.line   = tx_phase;
      st.paused = paused;
      st.window = window;
      expected_status_q.push_back(st);
   endfunction

   // Offer one word, hold it until taken, then predict
   task automatic send_word(input logic [pbst_pkg::REQ_W-1:0] code,
                            input logic [WORD_W-1:0] word,
                            input logic [SIDE_W-1:0] sides);
      int wait_cycles;
      wait_cycles = send_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
      if (wait_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= code;
      req_tx_word   <= word;
      req_side_mask <= sides;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_status(code, word, sides);
   endtask

   task automatic send_tick();
      send_word(pbst_pkg::REQ_TICK, WORD_W'($urandom), SIDE_W'($urandom));
   endtask

   // Drop valid and let every expected status come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status_q.size() != 0) @(posedge clock);
   endtask

   // Write both registers while the block is idle
   task automatic set_config(input logic [pbst_pkg::PULSE_W-1:0] pl,
                             input logic [pbst_pkg::GAP_W-1:0] gp);
      wait_until_drained();
      csr_wr_en <= 1'b1;
      csr_index <= pbst_pkg::CSR_PULSE_LENGTH;
      csr_wdata <= pl;
      @(posedge clock);
      csr_index <= pbst_pkg::CSR_GAP_PERIODS;
      csr_wdata <= {(pbst_pkg::CSR_W - pbst_pkg::GAP_W)'($urandom), gp};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pulse_cfg = pl;
      gap_cfg   = gp;
      @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // Mostly start-then-tick bursts with random content, some noise in between
   task automatic run_traffic(input int count);
      int sent;
      int ticks;
      int k;
      int r;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 85) begin
            if (paused && $urandom_range(0, 1))
               send_word(pbst_pkg::REQ_RESUME, WORD_W'($urandom), SIDE_W'($urandom));
            else
               send_word(pbst_pkg::REQ_START, pick_word(), SIDE_W'($urandom));
            ticks = $urandom_range(4, 40 + int'(gap_cfg) + int'(gap_cfg) / 2);
            for (k = 0; k < ticks; k++) begin
               r = $urandom_range(0, 99);
               if (r < 92)
                  send_tick();
               else if (r < 96)
                  send_word(pbst_pkg::REQ_START, pick_word(), SIDE_W'($urandom));
               else if (r < 98)
                  send_word(pbst_pkg::REQ_PAUSE, WORD_W'($urandom), SIDE_W'($urandom));
               else
                  send_word(pbst_pkg::REQ_RESUME, WORD_W'($urandom), SIDE_W'($urandom));
            end
            sent += ticks + 1;
            r = $urandom_range(0, 2);
            if (r == 0) begin
               send_word(pbst_pkg::REQ_STOP, WORD_W'($urandom), SIDE_W'($urandom));
               sent++;
            end else if (r == 1) begin
               send_word(pbst_pkg::REQ_PAUSE, WORD_W'($urandom), SIDE_W'($urandom));
               sent++;
            end
         end else begin
            ticks = $urandom_range(1, 5);
            for (k = 0; k < ticks; k++)
               send_word(pbst_pkg::REQ_W'($urandom_range(0, REQ_UNUSED_HI)),
                         WORD_W'($urandom), SIDE_W'($urandom));
            sent += ticks;
         end
      end
   endtask

   // Walk every request, the field extremes and the corner cases
   task automatic test_directed_cases();
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      set_config('1, '0);
      send_tick();
      send_word(pbst_pkg::REQ_START, '1, ALL_SIDES);
      repeat (3) send_tick();
      send_word(pbst_pkg::REQ_START, '0, '0);
      send_tick();
      send_word(pbst_pkg::REQ_STOP, '1, ALL_SIDES);
      send_word(pbst_pkg::REQ_PAUSE, '0, '0);
      send_word(pbst_pkg::REQ_START, 16'h8001, 2'b01);
      send_tick();
      send_word(pbst_pkg::REQ_RESUME, '0, '0);
      repeat (2) send_tick();
      send_word(pbst_pkg::REQ_STOP, '0, '0);
      // an all-zero word goes straight to the gap and reloads
      send_word(pbst_pkg::REQ_START, '0, 2'b10);
      repeat (3) send_tick();
      send_word(REQ_UNUSED_LO, '1, ALL_SIDES);
      send_word(REQ_UNUSED_LO + 1'b1, 16'h5555, 2'b01);
      send_word(REQ_UNUSED_HI, 16'hAAAA, 2'b10);
      send_word(pbst_pkg::REQ_PAUSE, '0, '0);
      send_word(pbst_pkg::REQ_RESUME, '1, '0);
   endtask

   task automatic test_quiet_line();
      set_config('0, '0);
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      run_traffic(300);
   endtask

   task automatic test_long_gaps();
      set_config('1, '1);
      send_idle_en = 1'b1;
      recv_idle_en = 1'b0;
      run_traffic(600);
   endtask

   task automatic test_random_config();
      set_config(pbst_pkg::PULSE_W'($urandom), pbst_pkg::GAP_W'($urandom_range(0, 40)));
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      run_traffic(350);
      set_config(pbst_pkg::PULSE_W'($urandom), pbst_pkg::GAP_W'($urandom));
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      run_traffic(350);
   endtask

   task automatic test_short_gaps();
      set_config(16'd1, 8'd1);
      send_idle_en = 1'b0;
      recv_idle_en = 1'b1;
      run_traffic(300);
   endtask

   // Hold the receiver off long enough for the input to back up
   task automatic test_backpressure();
      int k;
      set_config(pbst_pkg::PULSE_W'($urandom), pbst_pkg::GAP_W'($urandom_range(0, 3)));
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      hold_request = 80;
      send_word(pbst_pkg::REQ_START, pick_word(), ALL_SIDES);
      for (k = 0; k < 30; k++) send_tick();
   endtask

   // Drive stall and check each status that is taken
   initial begin
      line_status_type exp_status;
      int              stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: status word with none expected", $time);
            end else begin
               exp_status = expected_status_q.pop_front();
               compare_field("pulse_width", exp_status.width, rsp_pulse_width);
               compare_field("drive_sides", STATUS_W'(exp_status.sides),
                             STATUS_W'(rsp_drive_sides));
               compare_field("line_state", STATUS_W'(exp_status.line),
                             STATUS_W'(rsp_line_state));
               compare_field("is_paused", STATUS_W'(exp_status.paused),
                             STATUS_W'(rsp_is_paused));
               compare_field("sample_window", STATUS_W'(exp_status.window),
                             STATUS_W'(rsp_sample_window));
            end
            if (recv_idle_en) stall_left = $urandom_range(0, IDLE_MAX);
         end
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   function automatic void compare_field(string name, logic [STATUS_W-1:0] exp_v,
                                         logic [STATUS_W-1:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endfunction

   initial begin
      pulse_cfg  = '0;
      gap_cfg    = '0;
      shift_reg  = '0;
      held_word  = '0;
      tx_phase   = pbst_pkg::PHASE_IDLE;
      paused     = 1'b0;
      gap_left   = '0;
      line_width = '0;
      live_sides = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_quiet_line();
      test_long_gaps();
      test_random_config();
      test_short_gaps();
      test_backpressure();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Stop a hung run
   initial begin
      #20000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pbst_pkg.sv
rtl/pbst_core.sv
rtl/pbst_out_buf.sv
rtl/pulse_bit_serial_transmitter_unit.sv
dv/tb_top.sv
